// ===== sv/teq_pkg.sv =====
// shared constants, codes and types for the timer event queue
package teq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int TIME_BITS   = 32;
    localparam int ID_BITS     = 16;
    localparam int ADDR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);

    // stream widths
    localparam int ACTION_BITS = 2;
    localparam int STATUS_BITS = 2;
    localparam int S_DATA_BITS = 112;
    localparam int M_DATA_BITS = 24;

    // action codes
    localparam logic [ACTION_BITS-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_DELETE = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CHECK  = 2'd2;
    localparam logic [ACTION_BITS-1:0] ACT_HOLD   = 2'd3;

    // result status codes
    localparam logic [STATUS_BITS-1:0] RES_DONE      = 2'd0;
    localparam logic [STATUS_BITS-1:0] RES_NONE_DUE  = 2'd1;
    localparam logic [STATUS_BITS-1:0] RES_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] RES_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [TIME_BITS-1:0] due;
        logic [ID_BITS-1:0]   id;
    } slot_t;

    // controller to datapath
    typedef struct packed {
        logic                   load;
        logic                   start_add;
        logic                   start_walk;
        logic                   walk_pop;
        logic                   rd_en;
        logic                   rd_prev;
        logic                   add_shift;
        logic                   add_place;
        logic                   walk_step;
        logic                   walk_end;
        logic                   take_head;
        logic                   set_hold;
        logic                   finish;
        logic [STATUS_BITS-1:0] res_status;
        logic                   res_fired;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [ACTION_BITS-1:0] action;
        logic                   full;
        logic                   empty;
        logic                   ptr_zero;
        logic                   ptr_end;
        logic                   later;
        logic                   drop;
        logic                   blocked;
        logic                   hit;
        logic                   pop;
        logic                   out_busy;
    } dp_stat_t;

endpackage

// ===== sv/teq_datapath.sv =====
// queue storage, walk pointers, item and result registers
module teq_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic [teq_pkg::ACTION_BITS-1:0]   in_action,
    input  logic [teq_pkg::S_DATA_BITS-1:0]   in_data,
    input  teq_pkg::dp_cmd_t                  cmd,
    output teq_pkg::dp_stat_t                 stat,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [teq_pkg::M_DATA_BITS-1:0]   out_data
);
    import teq_pkg::*;

    slot_t                  mem [QUEUE_DEPTH];
    slot_t                  rd_data_reg;

    logic [ACTION_BITS-1:0] action_reg;
    logic [ID_BITS-1:0]     id_reg;
    logic [TIME_BITS-1:0]   due_reg;
    logic [TIME_BITS-1:0]   now_reg;
    logic [TIME_BITS-1:0]   hold_in_reg;

    logic [TIME_BITS-1:0]   hold_reg;
    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  ptr_reg;
    logic [COUNT_BITS-1:0]  wptr_reg;
    logic                   hit_reg;
    logic                   pop_reg;
    logic [ID_BITS-1:0]     pop_id_reg;

    logic                   out_valid_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic                   out_fired_reg;
    logic [ID_BITS-1:0]     out_id_reg;
    logic [COUNT_BITS-1:0]  out_count_reg;

    logic                   we;
    logic [ADDR_BITS-1:0]   waddr;
    slot_t                  wdata;
    logic [COUNT_BITS-1:0]  raddr_full;
    logic [ADDR_BITS-1:0]   raddr;

    // write port: shift up, place new entry, or compact down
    always_comb begin
        we    = 1'b0;
        waddr = ptr_reg[ADDR_BITS-1:0];
        wdata = rd_data_reg;
        if (cmd.add_shift) begin
            we = 1'b1;
        end else if (cmd.add_place) begin
            we          = 1'b1;
            wdata.due   = due_reg;
            wdata.id    = id_reg;
        end else if (cmd.walk_step && !stat.drop) begin
            we    = 1'b1;
            waddr = wptr_reg[ADDR_BITS-1:0];
        end
    end

    assign raddr_full = cmd.rd_prev ? ptr_reg - COUNT_BITS'(1) : ptr_reg;
    assign raddr      = raddr_full[ADDR_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en) begin
            rd_data_reg <= mem[raddr];
        end
    end

    // item capture and head id
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            action_reg  <= in_action;
            id_reg      <= in_data[ID_BITS-1:0];
            due_reg     <= in_data[ID_BITS +: TIME_BITS];
            now_reg     <= in_data[ID_BITS + TIME_BITS +: TIME_BITS];
            hold_in_reg <= in_data[ID_BITS + 2*TIME_BITS +: TIME_BITS];
        end
        if (cmd.take_head) begin
            pop_id_reg <= rd_data_reg.id;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg  <= '0;
            count_reg <= '0;
            ptr_reg   <= '0;
            wptr_reg  <= '0;
            hit_reg   <= 1'b0;
            pop_reg   <= 1'b0;
        end else begin
            if (cmd.set_hold) begin
                hold_reg <= hold_in_reg;
            end
            if (cmd.start_add) begin
                ptr_reg <= count_reg;
            end
            if (cmd.start_walk) begin
                ptr_reg  <= '0;
                wptr_reg <= '0;
                hit_reg  <= 1'b0;
                pop_reg  <= cmd.walk_pop;
            end
            if (cmd.add_shift) begin
                ptr_reg <= ptr_reg - COUNT_BITS'(1);
            end
            if (cmd.add_place) begin
                count_reg <= count_reg + COUNT_BITS'(1);
            end
            if (cmd.walk_step) begin
                ptr_reg <= ptr_reg + COUNT_BITS'(1);
                if (stat.drop) begin
                    hit_reg <= 1'b1;
                end else begin
                    wptr_reg <= wptr_reg + COUNT_BITS'(1);
                end
            end
            if (cmd.walk_end) begin
                count_reg <= wptr_reg;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_status_reg <= cmd.res_status;
            out_fired_reg  <= cmd.res_fired;
            out_id_reg     <= cmd.res_fired ? pop_id_reg : '0;
            out_count_reg  <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = {out_count_reg, out_id_reg, out_fired_reg, out_status_reg};

    always_comb begin
        stat.action   = action_reg;
        stat.full     = (count_reg == COUNT_BITS'(QUEUE_DEPTH));
        stat.empty    = (count_reg == '0);
        stat.ptr_zero = (ptr_reg == '0);
        stat.ptr_end  = (ptr_reg == count_reg);
        stat.later    = (rd_data_reg.due > due_reg);
        stat.drop     = pop_reg ? (ptr_reg == '0) : (rd_data_reg.id == id_reg);
        stat.blocked  = (hold_reg > now_reg) || (rd_data_reg.due > now_reg);
        stat.hit      = hit_reg;
        stat.pop      = pop_reg;
        stat.out_busy = out_valid_reg && !out_ready;
    end

endmodule

// ===== sv/teq_ctrl.sv =====
// sequencer for add, delete, check and hold actions
module teq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  teq_pkg::dp_stat_t  stat,
    output teq_pkg::dp_cmd_t   cmd
);
    import teq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_ADD_RD  = 4'd2;
    localparam logic [3:0] S_ADD_EV  = 4'd3;
    localparam logic [3:0] S_CHK_RD  = 4'd4;
    localparam logic [3:0] S_CHK_EV  = 4'd5;
    localparam logic [3:0] S_WALK_RD = 4'd6;
    localparam logic [3:0] S_WALK_EV = 4'd7;
    localparam logic [3:0] S_FINISH  = 4'd8;

    logic [3:0]             state_reg, state_next;
    logic [STATUS_BITS-1:0] status_reg, status_next;
    logic                   fired_reg, fired_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= RES_DONE;
            fired_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
            fired_reg  <= fired_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb begin
        cmd            = '0;
        cmd.res_status = status_reg;
        cmd.res_fired  = fired_reg;
        state_next     = state_reg;
        status_next    = status_reg;
        fired_next     = fired_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                fired_next  = 1'b0;
                status_next = RES_DONE;
                unique case (stat.action)
                    ACT_ADD: begin
                        if (stat.full) begin
                            status_next = RES_FULL;
                            state_next  = S_FINISH;
                        end else begin
                            cmd.start_add = 1'b1;
                            state_next    = S_ADD_RD;
                        end
                    end
                    ACT_DELETE: begin
                        cmd.start_walk = 1'b1;
                        state_next     = S_WALK_RD;
                    end
                    ACT_CHECK: begin
                        if (stat.empty) begin
                            status_next = RES_NONE_DUE;
                            state_next  = S_FINISH;
                        end else begin
                            cmd.start_walk = 1'b1;
                            cmd.walk_pop   = 1'b1;
                            state_next     = S_CHK_RD;
                        end
                    end
                    ACT_HOLD: begin
                        cmd.set_hold = 1'b1;
                        state_next   = S_FINISH;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_ADD_RD: begin
                if (stat.ptr_zero) begin
                    cmd.add_place = 1'b1;
                    state_next    = S_FINISH;
                end else begin
                    cmd.rd_en   = 1'b1;
                    cmd.rd_prev = 1'b1;
                    state_next  = S_ADD_EV;
                end
            end
            S_ADD_EV: begin
                if (stat.later) begin
                    cmd.add_shift = 1'b1;
                    state_next    = S_ADD_RD;
                end else begin
                    cmd.add_place = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_CHK_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_CHK_EV;
            end
            S_CHK_EV: begin
                if (stat.blocked) begin
                    status_next = RES_NONE_DUE;
                    state_next  = S_FINISH;
                end else begin
                    cmd.take_head = 1'b1;
                    state_next    = S_WALK_RD;
                end
            end
            S_WALK_RD: begin
                if (stat.ptr_end) begin
                    cmd.walk_end = 1'b1;
                    fired_next   = stat.pop;
                    status_next  = (stat.pop || stat.hit) ? RES_DONE : RES_NOT_FOUND;
                    state_next   = S_FINISH;
                end else begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_WALK_EV;
                end
            end
            S_WALK_EV: begin
                cmd.walk_step = 1'b1;
                state_next    = S_WALK_RD;
            end
            S_FINISH: begin
                if (!stat.out_busy) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

// ===== sv/timer_event_queue.sv =====
// top level of the timer event queue
//
// a sorted queue of up to sixteen timed events, earliest due time first, with
// equal times kept in arrival order. each input beat is one action: add an
// event, delete every event with an id, check the current time (pops the head
// when neither the hold time nor the head's due time lies ahead), or set the
// hold time. every action gives exactly one result beat. actions are handled
// one at a time; the queue sits in a single-port store with registered read,
// so each entry visited costs a read step and an evaluate step. an add visits
// the entries later than the new one, a delete and a popping check walk every
// entry held, a check that pops nothing reads only the head, and a hold, a
// dropped add or a check on an empty queue visits no entry. the result is
// only written when the output register is free, so a stalled result beat
// holds the sequencer. a finished result waits in the output register, and
// the next beat is taken while it waits.
module timer_event_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input beats
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [111:80] hold_time, [79:48] now_time, [47:16] event_time, [15:0] event_id
    input  logic [teq_pkg::S_DATA_BITS-1:0]   s_tdata,
    // [1:0] action
    input  logic [teq_pkg::ACTION_BITS-1:0]   s_tuser,
    // result beats
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [23:19] queue_count, [18:3] fired_id, [2] fired, [1:0] status
    output logic [teq_pkg::M_DATA_BITS-1:0]   m_tdata
);
    import teq_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // sequencer: one state per read or evaluate step of the walk
    teq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // storage, pointers, hold time and output register
    teq_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_action (s_tuser),
        .in_data   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

endmodule

// ===== sv/teq_checker.sv =====
// port checks for the timer event queue and their binding
module teq_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [teq_pkg::M_DATA_BITS-1:0]   m_tdata
);
    import teq_pkg::*;

    logic [STATUS_BITS-1:0] res_status;
    logic                   res_fired;
    logic [ID_BITS-1:0]     res_id;
    logic [COUNT_BITS-1:0]  res_count;

    assign res_status = m_tdata[STATUS_BITS-1:0];
    assign res_fired  = m_tdata[STATUS_BITS];
    assign res_id     = m_tdata[STATUS_BITS + 1 +: ID_BITS];
    assign res_count  = m_tdata[STATUS_BITS + 1 + ID_BITS +: COUNT_BITS];

    // a stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> res_count <= COUNT_BITS'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_fired |-> res_status == RES_DONE)
    else $error("fired with status other than done");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !res_fired |-> res_id == '0)
    else $error("fired id set without a pop");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && res_status == RES_FULL |-> res_count == COUNT_BITS'(QUEUE_DEPTH))
    else $error("dropped add while queue not full");

endmodule

bind timer_event_queue teq_checker u_teq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
